@@ design/bcg_pkg.sv @@
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared widths and register codes of the broadcast offset generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcg_pkg;

    localparam int IDX_W      = 32;
    localparam int CFG_W      = 64;
    localparam int RANK_W     = 3;
    localparam int CFG_ADDR_W = 3;

    // configuration register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RANK_OUT  = 3'd0,
        REG_RANK_A    = 3'd1,
        REG_RANK_B    = 3'd2,
        REG_SHAPE_OUT = 3'd3,
        REG_SHAPE_A   = 3'd4,
        REG_SHAPE_B   = 3'd5
    } t_cfg_reg;

    localparam logic [RANK_W-1:0] RANK_RESET  = 3'd1;
    localparam logic [CFG_W-1:0]  SHAPE_RESET = 64'h0001_0001_0001_0001;

endpackage : bcg_pkg

`default_nettype wire

@@ design/broadcast_offset_generator_top.sv @@
// datapath: the input passes the cell registers, then the product register, then the output register
// throughput: one item per cycle while the output is not stalled, set by the bit-per-cell conversion chain
// the whole pipeline stalls only while a finished result waits at the output
// configuration takes effect through the registered stride chain after its transfer
// reset: synchronous active-low, clears valids and restores register defaults
// ----------------------------------------------------------------------------
// broadcast_offset_generator_top
// Linear output index to broadcast operand offsets, via a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_offset_generator_top
    import bcg_pkg::*;
#(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [IDX_W-1:0]       i_out_index,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [IDX_W-1:0]            o_index_echo,
    output logic [IDX_W-1:0]            o_offset_a,
    output logic [IDX_W-1:0]            o_offset_b,
    output logic                        o_invalid
);

    localparam int USED_BITS = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
    localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> (IDX_W - USED_BITS);

    logic [RANK_W-1:0] r_rank_out, r_rank_a, r_rank_b;
    logic [CFG_W-1:0]  r_shape_out, r_shape_a, r_shape_b;
    logic              en;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_out  <= RANK_RESET;
            r_rank_a    <= RANK_RESET;
            r_rank_b    <= RANK_RESET;
            r_shape_out <= SHAPE_RESET;
            r_shape_a   <= SHAPE_RESET;
            r_shape_b   <= SHAPE_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_RANK_OUT:  r_rank_out  <= i_cfg_data[RANK_W-1:0];
                REG_RANK_A:    r_rank_a    <= i_cfg_data[RANK_W-1:0];
                REG_RANK_B:    r_rank_b    <= i_cfg_data[RANK_W-1:0];
                REG_SHAPE_OUT: r_shape_out <= i_cfg_data;
                REG_SHAPE_A:   r_shape_a   <= i_cfg_data;
                REG_SHAPE_B:   r_shape_b   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived strides
    logic [MAX_RANK-1:0]            use_a, use_b;
    logic [MAX_RANK-1:0][IDX_W-1:0] st_a, st_b;
    logic                           cfg_bad;

    bcg_stride #(.MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS)) u_stride (
        .i_clk       (i_clk),
        .i_rank_out  (r_rank_out),
        .i_rank_a    (r_rank_a),
        .i_rank_b    (r_rank_b),
        .i_shape_out (r_shape_out),
        .i_shape_a   (r_shape_a),
        .i_shape_b   (r_shape_b),
        .o_use_a     (use_a),
        .o_use_b     (use_b),
        .o_st_a      (st_a),
        .o_st_b      (st_b),
        .o_cfg_bad   (cfg_bad)
    );

    // pipeline advances unless a result is held at the output
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // cell chain, most significant index bit first
    logic [USED_BITS:0]                               s_valid;
    logic [USED_BITS:0][IDX_W-1:0]                    s_idx;
    logic [USED_BITS:0][MAX_RANK-1:0][DIM_BITS-1:0]   s_coord;
    logic [USED_BITS:0]                               s_ovf;

    assign s_valid[0] = i_in_valid;
    assign s_idx[0]   = i_out_index & IDX_MASK;
    assign s_coord[0] = '0;
    assign s_ovf[0]   = 1'b0;

    generate
        for (genvar k = 0; k < USED_BITS; k++) begin : g_cell
            bcg_cell #(
                .MAX_RANK (MAX_RANK),
                .DIM_BITS (DIM_BITS),
                .BIT_POS  (USED_BITS - 1 - k)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (en),
                .i_rank_out  (r_rank_out),
                .i_shape_out (r_shape_out),
                .i_valid     (s_valid[k]),
                .i_idx       (s_idx[k]),
                .i_coord     (s_coord[k]),
                .i_ovf       (s_ovf[k]),
                .o_valid     (s_valid[k+1]),
                .o_idx       (s_idx[k+1]),
                .o_coord     (s_coord[k+1]),
                .o_ovf       (s_ovf[k+1])
            );
        end
    endgenerate

    // product stage
    logic                           r_m_valid;
    logic [IDX_W-1:0]               r_m_idx;
    logic                           r_m_bad;
    logic [MAX_RANK-1:0][IDX_W-1:0] r_pa, r_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= s_valid[USED_BITS];
        end
    end

    generate
        for (genvar d = 0; d < MAX_RANK; d++) begin : g_prod
            logic [IDX_W+DIM_BITS-1:0] ma, mb;
            assign ma = s_coord[USED_BITS][d] * st_a[d];
            assign mb = s_coord[USED_BITS][d] * st_b[d];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_pa[d] <= use_a[d] ? ma[IDX_W-1:0] : '0;
                    r_pb[d] <= use_b[d] ? mb[IDX_W-1:0] : '0;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_idx <= s_idx[USED_BITS];
            r_m_bad <= s_ovf[USED_BITS] | cfg_bad;
        end
    end

    // sum and output register
    logic [IDX_W-1:0] sum_a, sum_b;
    always_comb begin
        sum_a = '0;
        sum_b = '0;
        for (int d = 0; d < MAX_RANK; d++) begin
            sum_a = sum_a + r_pa[d];
            sum_b = sum_b + r_pb[d];
        end
    end

    logic             r_out_valid;
    logic [IDX_W-1:0] r_echo, r_off_a, r_off_b;
    logic             r_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_echo    <= r_m_idx;
            r_off_a   <= r_m_bad ? '0 : sum_a;
            r_off_b   <= r_m_bad ? '0 : sum_b;
            r_invalid <= r_m_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_index_echo = r_echo;
    assign o_offset_a   = r_off_a;
    assign o_offset_b   = r_off_b;
    assign o_invalid    = r_invalid;

endmodule : broadcast_offset_generator_top

`default_nettype wire

@@ design/bcg_cell.sv @@
// ----------------------------------------------------------------------------
// bcg_cell
// One index bit of the mixed-radix conversion: shifts a bit into the
// per-dimension coordinates with one compare-subtract per dimension.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_cell
    import bcg_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16,
    parameter int BIT_POS  = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic [RANK_W-1:0]                  i_rank_out,
    input  wire logic [CFG_W-1:0]                   i_shape_out,
    input  wire logic                               i_valid,
    input  wire logic [IDX_W-1:0]                   i_idx,
    input  wire logic [MAX_RANK-1:0][DIM_BITS-1:0]  i_coord,
    input  wire logic                               i_ovf,
    output logic                                    o_valid,
    output logic [IDX_W-1:0]                        o_idx,
    output logic [MAX_RANK-1:0][DIM_BITS-1:0]       o_coord,
    output logic                                    o_ovf
);

    logic                              r_valid;
    logic [IDX_W-1:0]                  r_idx;
    logic [MAX_RANK-1:0][DIM_BITS-1:0] r_coord;
    logic                              r_ovf;
    logic [MAX_RANK-1:0][DIM_BITS-1:0] n_coord;
    logic                              n_carry;
    logic [DIM_BITS:0]                 t;
    logic [DIM_BITS-1:0]               so;

    // carry ripples from the last (fastest) dimension to the first
    always_comb begin
        n_coord = i_coord;
        n_carry = i_idx[BIT_POS];
        t       = '0;
        so      = '0;
        for (int d = MAX_RANK - 1; d >= 0; d--) begin
            if (d < int'(i_rank_out)) begin
                so = i_shape_out[d*DIM_BITS +: DIM_BITS];
                t  = {n_coord[d], n_carry};
                if (t >= {1'b0, so}) begin
                    t       = t - {1'b0, so};
                    n_carry = 1'b1;
                end else begin
                    n_carry = 1'b0;
                end
                n_coord[d] = t[DIM_BITS-1:0];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx   <= i_idx;
            r_coord <= n_coord;
            r_ovf   <= i_ovf | n_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_coord = r_coord;
    assign o_ovf   = r_ovf;

endmodule : bcg_cell

`default_nettype wire

@@ design/bcg_stride.sv @@
// ----------------------------------------------------------------------------
// bcg_stride
// Derives aligned operand dims, operand strides and the configuration
// error flag from the configuration registers; all outputs are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_stride
    import bcg_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic [RANK_W-1:0]            i_rank_out,
    input  wire logic [RANK_W-1:0]            i_rank_a,
    input  wire logic [RANK_W-1:0]            i_rank_b,
    input  wire logic [CFG_W-1:0]             i_shape_out,
    input  wire logic [CFG_W-1:0]             i_shape_a,
    input  wire logic [CFG_W-1:0]             i_shape_b,
    output logic [MAX_RANK-1:0]               o_use_a,
    output logic [MAX_RANK-1:0]               o_use_b,
    output logic [MAX_RANK-1:0][IDX_W-1:0]    o_st_a,
    output logic [MAX_RANK-1:0][IDX_W-1:0]    o_st_b,
    output logic                              o_cfg_bad
);

    logic [MAX_RANK-1:0][DIM_BITS-1:0] n_sa, n_sb, r_sa, r_sb;
    logic [MAX_RANK-1:0][IDX_W-1:0]    r_st_a, r_st_b;
    logic [MAX_RANK-1:0]               r_use_a, r_use_b;
    logic                              r_cfg_bad;
    logic                              n_bad;
    logic [RANK_W-1:0]                 pad_a, pad_b, ja, jb;
    logic [CFG_W-1:0]                  sh_a, sh_b;

    // right-aligned operand dims, leading ones
    always_comb begin
        pad_a = i_rank_out - i_rank_a;
        pad_b = i_rank_out - i_rank_b;
        ja    = '0;
        jb    = '0;
        sh_a  = '0;
        sh_b  = '0;
        for (int d = 0; d < MAX_RANK; d++) begin
            ja   = RANK_W'(d) - pad_a;
            jb   = RANK_W'(d) - pad_b;
            sh_a = i_shape_a >> (int'(ja) * DIM_BITS);
            sh_b = i_shape_b >> (int'(jb) * DIM_BITS);
            n_sa[d] = (d < int'(pad_a)) ? DIM_BITS'(1) : sh_a[DIM_BITS-1:0];
            n_sb[d] = (d < int'(pad_b)) ? DIM_BITS'(1) : sh_b[DIM_BITS-1:0];
        end
    end

    // configuration error check
    always_comb begin
        n_bad = (i_rank_out == '0) || (int'(i_rank_out) > MAX_RANK)
             || (i_rank_a > i_rank_out) || (i_rank_b > i_rank_out);
        for (int d = 0; d < MAX_RANK; d++) begin
            if (d < int'(i_rank_out)) begin
                if (i_shape_out[d*DIM_BITS +: DIM_BITS] == '0 || r_sa[d] == '0
                    || r_sb[d] == '0) begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_cfg_bad <= n_bad;
        for (int d = 0; d < MAX_RANK; d++) begin
            r_use_a[d] <= (d < int'(i_rank_out)) && (r_sa[d] != DIM_BITS'(1));
            r_use_b[d] <= (d < int'(i_rank_out)) && (r_sb[d] != DIM_BITS'(1));
        end
    end

    // stride chain, one registered multiply per dimension but the last, whose stride is one
    generate
        for (genvar d = 0; d < MAX_RANK; d++) begin : g_st
            if (d == MAX_RANK - 1) begin : g_last
                always_ff @(posedge i_clk) begin
                    r_st_a[d] <= IDX_W'(1);
                    r_st_b[d] <= IDX_W'(1);
                end
            end else begin : g_mid
                logic [IDX_W+DIM_BITS-1:0] pa, pb;
                assign pa = r_st_a[d+1] * r_sa[d+1];
                assign pb = r_st_b[d+1] * r_sb[d+1];
                always_ff @(posedge i_clk) begin
                    if (d + 1 >= int'(i_rank_out)) begin
                        r_st_a[d] <= IDX_W'(1);
                        r_st_b[d] <= IDX_W'(1);
                    end else begin
                        r_st_a[d] <= pa[IDX_W-1:0];
                        r_st_b[d] <= pb[IDX_W-1:0];
                    end
                end
            end
        end
    endgenerate

    assign o_use_a   = r_use_a;
    assign o_use_b   = r_use_b;
    assign o_st_a    = r_st_a;
    assign o_st_b    = r_st_b;
    assign o_cfg_bad = r_cfg_bad;

endmodule : bcg_stride

`default_nettype wire

@@ design/bcg_checker.sv @@
// ----------------------------------------------------------------------------
// bcg_checker
// Port-level checks of the broadcast offset generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_checker
    import bcg_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [IDX_W-1:0]  o_index_echo,
    input wire logic [IDX_W-1:0]  o_offset_a,
    input wire logic [IDX_W-1:0]  o_offset_b,
    input wire logic              o_invalid
);

    // an invalid result carries zero offsets
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid |-> o_offset_a == '0 && o_offset_b == '0)
        else $error("invalid result with nonzero offset");

    // input side is open whenever the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_index_echo)
            && $stable(o_offset_a) && $stable(o_offset_b) && $stable(o_invalid))
        else $error("output changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule : bcg_checker

bind broadcast_offset_generator_top bcg_checker u_bcg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_index_echo (o_index_echo),
    .o_offset_a   (o_offset_a),
    .o_offset_b   (o_offset_b),
    .o_invalid    (o_invalid)
);

`default_nettype wire
